// File: rtl/core/undirected_cycle_detect_macros.svh
// Assertion helpers shared by the checker
`ifndef UNDIRECTED_CYCLE_DETECT_MACROS_SVH
`define UNDIRECTED_CYCLE_DETECT_MACROS_SVH
// assert that a |-> b at each edge, skipping reset
`define UCD_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// assert that a |=> b
`define UCD_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// File: rtl/core/ucd_pkg.sv
package ucd_pkg;
    localparam int MAX_VERTICES = 256;
    localparam int MAX_EDGES    = 1024;
    localparam int ENTRY_CAP    = 2 * MAX_EDGES;
    localparam int VW           = $clog2(MAX_VERTICES);
    localparam int EW           = $clog2(ENTRY_CAP) + 1;
    localparam int CW           = $clog2(MAX_VERTICES) + 1;
    localparam logic [EW-1:0] NO_ENTRY = EW'(ENTRY_CAP);

    typedef struct packed {
        logic [VW-1:0] vertex;
        logic [VW-1:0] parent;
        logic          has_parent;
        logic [EW-1:0] pos;
    } frame_t;
endpackage

// File: rtl/core/undirected_cycle_detect.sv
// Channel   Dir  Payload (low bit up)
// s_axis    in   tdata: end_a[7:0] end_b[15:8]; tuser: edge_present[0] last_edge[1]
// m_axis    out  tdata: cycle_found[0] load_error[1]
// cfg       in   data: vertex_count[8:0]
// An edge item steps through: accept, read the head of end_a, write its entry and head,
// read the head of end_b, write its entry and head. Any other item is done on accept.
// A last item then sweeps the seen memory and walks: S_SCAN, S_SCANW per start vertex;
// S_TOP, S_EDGE, S_EDGEW, S_PUSH per entry followed; S_TOP, S_EDGE per frame popped.
// Reset: async, active low; after reset a sweep clears heads and seen marks.
// The result is held until taken, then a sweep clears the graph; no item meanwhile.
module undirected_cycle_detect
    import ucd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // end_a, end_b
    input  logic [1:0]  s_axis_tuser,   // edge_present, last_edge
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // cycle_found, load_error, zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);
    typedef enum logic [13:0] {
        S_CLR   = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_LA    = 14'b00000000000100,
        S_WA    = 14'b00000000001000,
        S_LB    = 14'b00000000010000,
        S_WB    = 14'b00000000100000,
        S_SCAN  = 14'b00000001000000,
        S_SCANW = 14'b00000010000000,
        S_TOP   = 14'b00000100000000,
        S_EDGE  = 14'b00001000000000,
        S_EDGEW = 14'b00010000000000,
        S_PUSH  = 14'b00100000000000,
        S_OUT   = 14'b01000000000000,
        S_SEEN  = 14'b10000000000000
    } state_t;

    state_t        state_reg;
    logic [8:0]    vc_reg;
    logic [VW:0]   cnt_reg;
    logic [EW-1:0] ecount_reg;
    logic          err_reg, cyc_reg, res_last_reg;
    logic [VW-1:0] a_reg, b_reg;
    logic [VW:0]   sp_reg;
    frame_t        top_reg;
    logic [VW-1:0] w_reg;
    logic          last_reg;

    wire [CW-1:0] nact = (vc_reg > 9'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vc_reg);

    // head memory
    logic          h_we;
    logic [VW-1:0] h_wa, h_ra;
    logic [EW-1:0] h_wd, h_rd;
    ucd_ram #(.AW(VW), .DW(EW)) u_head (.clk, .we(h_we), .waddr(h_wa), .wdata(h_wd),
        .raddr(h_ra), .rdata(h_rd));
    // seen memory
    logic          s_we, s_wd, s_rd;
    logic [VW-1:0] s_wa, s_ra;
    ucd_ram #(.AW(VW), .DW(1)) u_seen (.clk, .we(s_we), .waddr(s_wa), .wdata(s_wd),
        .raddr(s_ra), .rdata(s_rd));
    // adjacency memory: target + next
    logic                   l_we;
    logic [EW-2:0]          l_wa, l_ra;
    logic [VW+EW-1:0]       l_wd, l_rd;
    ucd_ram #(.AW(EW-1), .DW(VW+EW)) u_list (.clk, .we(l_we), .waddr(l_wa),
        .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
    // walk stack
    logic                   k_we;
    logic [VW-1:0]          k_wa, k_ra;
    frame_t                 k_wd, k_rd;
    ucd_ram #(.AW(VW), .DW($bits(frame_t))) u_stack (.clk, .we(k_we), .waddr(k_wa),
        .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {6'd0, err_reg, cyc_reg};

    wire edge_ok = (CW'(s_axis_tdata[7:0]) < nact) && (CW'(s_axis_tdata[15:8]) < nact)
                   && (ecount_reg + EW'(2) <= NO_ENTRY);

    // combinational memory controls
    always_comb
    begin
        h_we = 1'b0; h_wa = a_reg; h_wd = ecount_reg; h_ra = a_reg;
        s_we = 1'b0; s_wa = cnt_reg[VW-1:0]; s_wd = 1'b0; s_ra = cnt_reg[VW-1:0];
        l_we = 1'b0; l_wa = ecount_reg[EW-2:0]; l_wd = '0;
        l_ra = top_reg.pos[EW-2:0];
        k_we = 1'b0; k_wa = sp_reg[VW-1:0]; k_wd = top_reg;
        k_ra = sp_reg[VW-1:0] - VW'(1);
        unique case (state_reg)
            S_CLR, S_SEEN:
            begin
                // heads are cleared only after reset and after a result
                h_we = (state_reg == S_CLR) || res_last_reg;
                h_wa = cnt_reg[VW-1:0]; h_wd = NO_ENTRY;
                s_we = 1'b1;
            end
            S_IDLE:  h_ra = s_axis_tdata[7:0];
            S_LA:    h_ra = a_reg;
            S_WA:
            begin
                l_we = 1'b1; l_wd = {b_reg, h_rd};
                h_we = 1'b1; h_wa = a_reg;
                h_ra = b_reg;
            end
            S_LB:    h_ra = b_reg;
            S_WB:
            begin
                l_we = 1'b1; l_wd = {a_reg, (a_reg == b_reg) ? ecount_reg - EW'(1) : h_rd};
                h_we = 1'b1; h_wa = b_reg;
            end
            S_SCAN:  h_ra = cnt_reg[VW-1:0];
            S_SCANW:
                // unseen start vertex: mark it and place the root frame
                if (!s_rd)
                begin
                    s_we = 1'b1; s_wd = 1'b1;
                    k_we = 1'b1; k_wa = '0;
                    k_wd = '{vertex: cnt_reg[VW-1:0], parent: '0, has_parent: 1'b0,
                             pos: h_rd};
                end
            S_TOP:   ;
            S_EDGE:  l_ra = k_rd.pos[EW-2:0];
            S_EDGEW:
            begin
                // advance the top frame past this entry, fetch the neighbor
                k_we = 1'b1; k_wa = sp_reg[VW-1:0] - VW'(1);
                k_wd = top_reg; k_wd.pos = l_rd[EW-1:0];
                s_ra = l_rd[VW+EW-1:EW]; h_ra = l_rd[VW+EW-1:EW];
            end
            S_PUSH:
                if (!s_rd)
                begin
                    s_we = 1'b1; s_wa = w_reg; s_wd = 1'b1;
                    if (sp_reg < (VW+1)'(MAX_VERTICES))
                    begin
                        k_we = 1'b1; k_wa = sp_reg[VW-1:0];
                        k_wd = '{vertex: w_reg, parent: top_reg.vertex, has_parent: 1'b1,
                                 pos: h_rd};
                    end
                end
            S_OUT:   ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR; vc_reg <= 9'd256; cnt_reg <= '0; ecount_reg <= '0;
            err_reg <= 1'b0; cyc_reg <= 1'b0; res_last_reg <= 1'b0; sp_reg <= '0;
            last_reg <= 1'b0; a_reg <= '0; b_reg <= '0; top_reg <= '0; w_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) vc_reg <= cfg_data;
            unique case (state_reg)
                S_CLR, S_SEEN:
                begin
                    cnt_reg <= cnt_reg + (VW+1)'(1);
                    if (cnt_reg == (VW+1)'(MAX_VERTICES - 1))
                    begin
                        cnt_reg <= '0;
                        state_reg <= (state_reg == S_SEEN && !res_last_reg) ? S_SCAN : S_IDLE;
                        if (state_reg == S_SEEN && res_last_reg)
                        begin
                            res_last_reg <= 1'b0; ecount_reg <= '0; err_reg <= 1'b0;
                        end
                    end
                end
                S_IDLE:
                    if (s_axis_tvalid)
                    begin
                        a_reg <= s_axis_tdata[7:0]; b_reg <= s_axis_tdata[15:8];
                        last_reg <= s_axis_tuser[1];
                        if (s_axis_tuser[0] && edge_ok) state_reg <= S_LA;
                        else
                        begin
                            if (s_axis_tuser[0]) err_reg <= 1'b1;
                            if (s_axis_tuser[1])
                            begin
                                cnt_reg <= '0; state_reg <= S_SEEN;
                            end
                        end
                    end
                S_LA: state_reg <= S_WA;
                S_WA:
                begin
                    ecount_reg <= ecount_reg + EW'(1); state_reg <= S_LB;
                end
                S_LB: state_reg <= S_WB;
                S_WB:
                begin
                    ecount_reg <= ecount_reg + EW'(1); cnt_reg <= '0;
                    state_reg <= last_reg ? S_SEEN : S_IDLE;
                end
                S_SCAN:
                    if (CW'(cnt_reg) >= nact)
                    begin
                        cyc_reg <= 1'b0; state_reg <= S_OUT;
                    end
                    else state_reg <= S_SCANW;
                S_SCANW:
                    if (s_rd)
                    begin
                        cnt_reg <= cnt_reg + (VW+1)'(1); state_reg <= S_SCAN;
                    end
                    else
                    begin
                        sp_reg <= (VW+1)'(1);
                        state_reg <= S_TOP;
                    end
                S_TOP: state_reg <= S_EDGE;
                S_EDGE:
                begin
                    top_reg <= k_rd;
                    // list exhausted: drop the frame, back to the scan after the root
                    if (k_rd.pos >= NO_ENTRY)
                    begin
                        sp_reg <= sp_reg - (VW+1)'(1);
                        if (sp_reg == (VW+1)'(1))
                        begin
                            cnt_reg <= cnt_reg + (VW+1)'(1);
                            state_reg <= S_SCAN;
                        end
                        else state_reg <= S_TOP;
                    end
                    else state_reg <= S_EDGEW;
                end
                S_EDGEW:
                begin
                    w_reg <= l_rd[VW+EW-1:EW];
                    top_reg.pos <= l_rd[EW-1:0];
                    state_reg <= S_PUSH;
                end
                S_PUSH:
                    if (!s_rd)
                    begin
                        if (sp_reg < (VW+1)'(MAX_VERTICES)) sp_reg <= sp_reg + (VW+1)'(1);
                        state_reg <= S_TOP;
                    end
                    else if (!top_reg.has_parent || top_reg.parent != w_reg)
                    begin
                        cyc_reg <= 1'b1; state_reg <= S_OUT;
                    end
                    else state_reg <= S_TOP;
                S_OUT:
                    if (m_axis_tready)
                    begin
                        res_last_reg <= 1'b1; cnt_reg <= '0; state_reg <= S_SEEN;
                    end
                default: state_reg <= S_CLR;
            endcase
        end
    end
endmodule

// File: rtl/core/ucd_ram.sv
module ucd_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/ucd_checker.sv
`include "undirected_cycle_detect_macros.svh"
module ucd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    `UCD_ASSERT_IMPL(a_excl, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    `UCD_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `UCD_ASSERT_IMPL(a_pad, clk, rst_n, m_axis_tvalid, m_axis_tdata[7:2] == 6'd0)
    `UCD_ASSERT_NEXT(a_drop, clk, rst_n, m_axis_tvalid && m_axis_tready, !m_axis_tvalid)
endmodule

bind undirected_cycle_detect ucd_checker u_chk (.clk, .rst_n, .s_axis_tvalid,
    .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);
